FILE: src/ttct_pkg.sv
// Shared types and constants for the tree topology count table.
// Holds the query and result word layouts, the sequencer states and register codes.
// No dependencies.
package ttct_pkg;

	localparam int TAXA_W  = 6;
	localparam int NODES_W = 5;
	localparam int CNT_W   = 64;

	localparam logic [CNT_W-1:0] SAT_MAX = {CNT_W{1'b1}};

	// Register index of the rooted-mode bit (byte address 0, index taken from paddr[2])
	localparam logic [0:0] REG_ROOTED = 1'b0;

	typedef struct packed {
		logic [TAXA_W-1:0]  taxa;
		logic [NODES_W-1:0] internal_nodes;
	} query_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] saturated_count;
		logic [CNT_W-1:0] total_count;
		logic             saturated;
		logic             bad_query;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_INIT,
		ST_MULP,
		ST_MULO,
		ST_ACC,
		ST_LOOKUP,
		ST_RESULT
	} state_t;

endpackage

FILE: src/tree_topology_count_table.sv
// Tree topology count table: cached triangle of tree counts per internal-node count.
// Top level; one module with its table memory and a shared saturating multiplier.
// Depends on ttct_pkg.
//
// Sequence from start accepted to done strobe:
//   cached hit (good or bad node count): check, table read, result, strobe.
//   bad taxa: check, result, strobe.
//   rebuild: check, init, then every triangle entry of rows 2..top, then table read, result,
//   strobe; top = taxa-1 (rooted) or taxa-2 (unrooted). Each entry uses the single 64 x 6 bit
//   saturating multiplier twice, then one add/write step.
// Throughput: one query at a time; busy is high from acceptance until the result cycle.
// Reset: async active low; clears the sequencer, the cache tags and the rooted bit.
// The table memory itself is not cleared; every entry whose value is used is written by a rebuild first.
// The result word is held for exactly one cycle under done; the receiver cannot stall.
module tree_topology_count_table #(
	parameter int MAX_TAXA = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	// query channel
	input  logic              start,
	output logic              busy,
	input  ttct_pkg::query_t  query,
	// result channel
	output logic              done,
	output ttct_pkg::result_t result,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import ttct_pkg::*;

	// RW: row/column counters (top <= MAX_TAXA-1); AW: table address; FW: multiplier factor
	localparam int RW = $clog2(MAX_TAXA);
	localparam int AW = $clog2(MAX_TAXA + 1);
	localparam int FW = RW + 1;
	localparam int DEPTH = MAX_TAXA + 1;

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic rooted_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rooted_q <= 1'b0;
		end else if (cfg_wr && paddr[2] == REG_ROOTED) begin
			rooted_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_ROOTED) begin
			prdata[0] = rooted_q;
		end
	end

	// ------------------------------------------------------------------
	// State and datapath registers
	// ------------------------------------------------------------------
	state_t state_q, state_d;

	logic [TAXA_W-1:0]  taxa_q;
	logic [NODES_W-1:0] nodes_q;
	logic [TAXA_W-1:0]  cached_taxa_q;
	logic               cached_rooted_q;
	logic               valid_q;
	logic               taxa_bad_q;
	logic               nodes_ok_q;
	logic [RW-1:0]      top_q;
	logic [RW-1:0]      m_q;      // current row of the triangle
	logic [RW-1:0]      k_q;      // current column within the row
	logic [CNT_W-1:0]   prev_q;   // T(m-1,k-1), carried along the row
	logic [CNT_W-1:0]   old_q;    // T(m-1,k), read back from the table
	logic [CNT_W-1:0]   acc_q;    // (m+k-1) * prev term
	logic [CNT_W-1:0]   prod_q;   // k * old term
	logic [CNT_W-1:0]   satc_q;   // entry at top (fully resolved trees)
	logic [CNT_W-1:0]   total_q;  // saturating sum of the last row
	logic [CNT_W-1:0]   rd_q;     // registered table read data
	logic               done_q;
	result_t            result_q;

	// ------------------------------------------------------------------
	// Check-stage decode
	// ------------------------------------------------------------------
	logic              taxa_bad;
	logic [TAXA_W-1:0] top_calc;
	logic              nodes_ok;
	logic              need_build;

	assign taxa_bad = (taxa_q < TAXA_W'(2)) || (7'(taxa_q) > 7'(MAX_TAXA));
	assign top_calc = taxa_q - (rooted_q ? TAXA_W'(1) : TAXA_W'(2));
	assign nodes_ok = (nodes_q != '0) && (7'(nodes_q) <= 7'(top_calc));
	assign need_build = !valid_q || (taxa_q != cached_taxa_q) || (rooted_q != cached_rooted_q);

	// ------------------------------------------------------------------
	// Shared saturating multiplier: 64-bit operand times a small factor
	// ------------------------------------------------------------------
	logic [CNT_W-1:0]    mul_a;
	logic [FW-1:0]       mul_b;
	logic [CNT_W+FW-1:0] mul_full;
	logic [CNT_W-1:0]    mul_out;

	// T(m-1,k) is taken straight from the read port; the read issued in the
	// first multiply cycle always sees the write of the previous entry
	always_comb begin
		if (state_q == ST_MULO) begin
			mul_a = rd_q;
			mul_b = FW'(k_q);
		end else begin
			mul_a = prev_q;
			mul_b = FW'(m_q) + FW'(k_q) - FW'(1);
		end
	end

	assign mul_full = mul_a * mul_b;
	assign mul_out  = (mul_full[CNT_W+FW-1:CNT_W] != '0) ? SAT_MAX : mul_full[CNT_W-1:0];

	// saturating adds: new entry and running total
	logic [CNT_W:0]   ent_sum;
	logic [CNT_W-1:0] ent_val;
	logic [CNT_W:0]   tot_sum;
	logic [CNT_W-1:0] tot_val;

	assign ent_sum = {1'b0, acc_q} + {1'b0, prod_q};
	assign ent_val = ent_sum[CNT_W] ? SAT_MAX : ent_sum[CNT_W-1:0];
	assign tot_sum = {1'b0, total_q} + {1'b0, ent_val};
	assign tot_val = tot_sum[CNT_W] ? SAT_MAX : tot_sum[CNT_W-1:0];

	logic row_end;
	logic last_row;
	assign row_end  = (k_q == m_q);
	assign last_row = (m_q == top_q);

	// ------------------------------------------------------------------
	// Sequencer: next state and memory controls
	// ------------------------------------------------------------------
	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	logic [CNT_W-1:0] mem_wd;
	logic [AW-1:0]    mem_ra;

	always_comb begin
		state_d = state_q;
		mem_we  = 1'b0;
		mem_wa  = AW'(k_q);
		mem_wd  = ent_val;
		mem_ra  = AW'(k_q);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (taxa_bad) begin
					state_d = ST_RESULT;
				end else if (need_build) begin
					state_d = ST_INIT;
				end else begin
					state_d = ST_LOOKUP;
				end
			end
			ST_INIT: begin
				// column 1 is always one
				mem_we = 1'b1;
				mem_wa = AW'(1);
				mem_wd = CNT_W'(1);
				state_d = (top_q < RW'(2)) ? ST_LOOKUP : ST_MULP;
			end
			ST_MULP: begin
				state_d = ST_MULO;
			end
			ST_MULO: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				mem_we = 1'b1;
				if (row_end) begin
					state_d = last_row ? ST_LOOKUP : ST_MULP;
				end else begin
					state_d = ST_MULP;
				end
			end
			ST_LOOKUP: begin
				mem_ra  = AW'(7'(nodes_q));
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// Table memory: one write port, one registered read port
	// ------------------------------------------------------------------
	logic [CNT_W-1:0] table_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[mem_wa] <= mem_wd;
		end
		rd_q <= table_mem[mem_ra];
	end

	// ------------------------------------------------------------------
	// Control registers (cache tags, strobe)
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q         <= 1'b0;
			cached_taxa_q   <= '0;
			cached_rooted_q <= 1'b0;
			done_q          <= 1'b0;
		end else begin
			done_q <= (state_q == ST_RESULT);
			if (state_q == ST_CHECK && !taxa_bad && need_build) begin
				valid_q         <= 1'b1;
				cached_taxa_q   <= taxa_q;
				cached_rooted_q <= rooted_q;
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	logic [CNT_W-1:0] res_cnt;
	logic [CNT_W-1:0] res_satc;
	logic [CNT_W-1:0] res_tot;

	assign res_cnt  = (!taxa_bad_q && nodes_ok_q) ? rd_q : '0;
	assign res_satc = taxa_bad_q ? '0 : satc_q;
	assign res_tot  = taxa_bad_q ? '0 : total_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					taxa_q  <= query.taxa;
					nodes_q <= query.internal_nodes;
				end
			end
			ST_CHECK: begin
				taxa_bad_q <= taxa_bad;
				nodes_ok_q <= nodes_ok;
				top_q      <= RW'(top_calc);
			end
			ST_INIT: begin
				m_q     <= RW'(2);
				k_q     <= RW'(2);
				prev_q  <= CNT_W'(1);
				satc_q  <= CNT_W'(1);
				total_q <= CNT_W'(1);
			end
			ST_MULP: begin
				acc_q <= mul_out;
			end
			ST_MULO: begin
				old_q  <= rd_q;
				// the last column has no T(m-1,k) term
				prod_q <= (k_q < m_q) ? mul_out : '0;
			end
			ST_ACC: begin
				if (last_row) begin
					total_q <= tot_val;
					if (row_end) begin
						satc_q <= ent_val;
					end
				end
				if (row_end) begin
					m_q    <= m_q + RW'(1);
					k_q    <= RW'(2);
					prev_q <= CNT_W'(1);
				end else begin
					k_q    <= k_q + RW'(1);
					prev_q <= old_q;
				end
			end
			ST_LOOKUP: begin
			end
			ST_RESULT: begin
				result_q.count           <= res_cnt;
				result_q.saturated_count <= res_satc;
				result_q.total_count     <= res_tot;
				result_q.saturated       <= (res_cnt == SAT_MAX) || (res_satc == SAT_MAX)
				                            || (res_tot == SAT_MAX);
				result_q.bad_query       <= taxa_bad_q || !nodes_ok_q;
			end
			default: begin
			end
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// the strobe only follows the result-forming cycle
	a_done_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_RESULT))
		else $error("done without a preceding result cycle");

	// triangle walk stays inside rows 2..top and columns 2..m
	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC) |-> (k_q >= RW'(2) && k_q <= m_q && m_q <= top_q))
		else $error("triangle index out of bounds");

	// a good query always reports at least one fully resolved tree and a nonzero total
	a_satc_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.bad_query) |-> (result.saturated_count != '0
		&& result.total_count != '0))
		else $error("zero count on a valid query");

	// a rebuild can only start from a fresh check
	a_init_from_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT) |-> ($past(state_q) == ST_CHECK && valid_q))
		else $error("rebuild entered out of sequence");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for tree_topology_count_table.
// Predicts each result word from its own copy of the count triangle and checks done strobes.
// Depends on ttct_pkg and the tree_topology_count_table RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ttct_pkg::*;

	localparam int MAX_TAXA  = 32;
	localparam int TABLE_LEN = MAX_TAXA + 1;
	// idle cycles after the last strobe before a register write or the end of run
	localparam int DRAIN_SLACK = 8;

	// ------------------------------------------------------------------
	// DUT signals
	// ------------------------------------------------------------------
	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	query_t      query;
	logic        done;
	result_t     result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	tree_topology_count_table #(
		.MAX_TAXA(MAX_TAXA)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.query   (query),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor state: mirrors the cached triangle row and its tags.
	// Values below are the post-reset state.
	// ------------------------------------------------------------------
	logic [CNT_W-1:0]   tree_counts [TABLE_LEN];
	logic [CNT_W-1:0]   tree_total     = '0;
	int unsigned        table_top      = 1;
	logic [TAXA_W-1:0]  cached_taxa    = '0;
	bit                 table_valid    = 1'b0;
	bit                 cached_rooted  = 1'b0;
	bit                 rooted_mode    = 1'b0;

	// expected result words, oldest first
	result_t            pending_results [$];
	result_t            want;

	// run statistics and failure count
	int unsigned        queries_sent      = 0;
	int unsigned        results_seen      = 0;
	int unsigned        table_rebuilds    = 0;
	int unsigned        bad_results       = 0;
	int unsigned        saturated_results = 0;
	int unsigned        failures          = 0;

	// gap control: while burst_left is nonzero the sender never idles
	int unsigned        burst_left        = 0;

	// ------------------------------------------------------------------
	// Saturating 64-bit arithmetic (computed wide, clamped at all ones)
	// ------------------------------------------------------------------
	function automatic logic [CNT_W-1:0] sat_mul(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [2*CNT_W-1:0] p;
		p = a * b;
		return (p[2*CNT_W-1:CNT_W] != '0) ? SAT_MAX : p[CNT_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = a + b;
		return s[CNT_W] ? SAT_MAX : s[CNT_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Count predictor. Updates the cached triangle when the taxa, the
	// rooting mode or the validity tag misses, then forms the result word.
	// ------------------------------------------------------------------
	function automatic result_t predict_counts(input query_t q);
		result_t          r;
		int unsigned      taxa;
		int unsigned      nodes;
		int unsigned      top;
		int unsigned      m;
		int unsigned      k;
		logic [CNT_W-1:0] prev;
		logic [CNT_W-1:0] old;
		logic [CNT_W-1:0] c;
		taxa  = 32'(q.taxa);
		nodes = 32'(q.internal_nodes);
		r     = '0;
		if (taxa < 2 || taxa > MAX_TAXA) begin
			// taxa out of range: nothing cached changes, all counts zero
			r.bad_query = 1'b1;
		end else begin
			top = taxa - (rooted_mode ? 1 : 2);
			if (!table_valid || taxa != 32'(cached_taxa) || rooted_mode != cached_rooted) begin
				for (k = 0; k < TABLE_LEN; k++)
					tree_counts[k] = '0;
				tree_counts[1] = CNT_W'(1);
				// row m overwrites row m-1 in place, walking k upward
				for (m = 2; m <= top && m < TABLE_LEN; m++) begin
					prev = tree_counts[1];
					tree_counts[m] = '0;
					for (k = 2; k <= m; k++) begin
						old = tree_counts[k];
						c = sat_mul(prev, CNT_W'(m + k - 1));
						if (k < m)
							c = sat_add(c, sat_mul(old, CNT_W'(k)));
						tree_counts[k] = c;
						prev = old;
					end
				end
				// two unrooted taxa: built as a one-entry table
				table_top  = (top < 1) ? 1 : top;
				tree_total = '0;
				for (k = 1; k <= table_top; k++)
					tree_total = sat_add(tree_total, tree_counts[k]);
				cached_taxa   = TAXA_W'(taxa);
				cached_rooted = rooted_mode;
				table_valid   = 1'b1;
				table_rebuilds++;
			end
			r.saturated_count = tree_counts[table_top];
			r.total_count     = tree_total;
			if (nodes >= 1 && nodes <= top)
				r.count = tree_counts[nodes];
			else
				r.bad_query = 1'b1;
		end
		r.saturated = (r.count == SAT_MAX) || (r.saturated_count == SAT_MAX) ||
			(r.total_count == SAT_MAX);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Sender gaps: mostly short, a few long, with gap-free bursts.
	// ------------------------------------------------------------------
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (burst_left != 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(99);
		if (r < 5) begin
			burst_left = $urandom_range(60, 15);
			return 0;
		end
		if (r < 60)
			return $urandom_range(2, 0);
		if (r < 93)
			return $urandom_range(10, 3);
		return $urandom_range(60, 20);
	endfunction

	// Send one query word: hold start until the block takes it, record the
	// prediction at the accepting edge, then idle for a random gap. start
	// stays high across a zero gap so it is never dropped and re-raised.
	task automatic send_query(input logic [TAXA_W-1:0] taxa,
		input logic [NODES_W-1:0] nodes);
		query_t      q;
		int unsigned gap;
		q.taxa           = taxa;
		q.internal_nodes = nodes;
		start <= 1'b1;
		query <= q;
		do
			@(posedge clk);
		while (busy);
		pending_results = {pending_results, predict_counts(q)};
		queries_sent++;
		gap = pick_gap();
		if (gap != 0) begin
			start <= 1'b0;
			query <= '{taxa: TAXA_W'($urandom), internal_nodes: NODES_W'($urandom)};
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every predicted word has been strobed out.
	task automatic wait_drained();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	// APB write of the rooted bit; only issued with the block idle.
	task automatic write_rooted(input bit value);
		wait_drained();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_ROOTED, 2'b00};
		pwdata  <= {31'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		rooted_mode = value;
	endtask

	// ------------------------------------------------------------------
	// Result checker: every done strobe is matched against the oldest
	// prediction, field by field.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result word strobed with no query outstanding");
				failures++;
			end else begin
				want = pending_results.pop_front();
				if (want.bad_query)
					bad_results++;
				if (want.saturated)
					saturated_results++;
				if (result.count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, result.count);
					failures++;
				end
				if (result.saturated_count !== want.saturated_count) begin
					$error("saturated_count: expected %0d, got %0d",
						want.saturated_count, result.saturated_count);
					failures++;
				end
				if (result.total_count !== want.total_count) begin
					$error("total_count: expected %0d, got %0d",
						want.total_count, result.total_count);
					failures++;
				end
				if (result.saturated !== want.saturated) begin
					$error("saturated: expected %0d, got %0d", want.saturated, result.saturated);
					failures++;
				end
				if (result.bad_query !== want.bad_query) begin
					$error("bad_query: expected %0d, got %0d", want.bad_query, result.bad_query);
					failures++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Unrooted corners: two taxa (empty valid range, table of one), one
	// internal node, top of range and one past it, bad taxa on both sides.
	task automatic test_unrooted_corners();
		write_rooted(1'b0);
		send_query(6'd2, 5'd0);
		send_query(6'd2, 5'd1);
		send_query(6'd3, 5'd1);
		send_query(6'd3, 5'd2);
		send_query(6'd4, 5'd1);
		send_query(6'd4, 5'd2);
		send_query(6'd4, 5'd3);
		send_query(6'd32, 5'd30);
		send_query(6'd32, 5'd1);
		send_query(6'd32, 5'd31);
		send_query(6'd32, 5'd0);
		// bad taxa must leave the 32-taxa table cached
		send_query(6'd0, 5'd5);
		send_query(6'd1, 5'd1);
		send_query(6'd33, 5'd3);
		send_query(6'd63, 5'd31);
	endtask

	// Rooted corners: same taxa as cached but new mode forces a rebuild;
	// 32 taxa saturates the fully resolved count and the total.
	task automatic test_rooted_corners();
		write_rooted(1'b1);
		send_query(6'd32, 5'd31);
		send_query(6'd32, 5'd15);
		send_query(6'd2, 5'd1);
		send_query(6'd2, 5'd2);
		send_query(6'd3, 5'd2);
		send_query(6'd31, 5'd30);
		send_query(6'd40, 5'd7);
	endtask

	// Random traffic in one rooting mode. Mostly valid queries against a
	// sticky taxa value (cache hits), some taxa changes (rebuilds, mostly
	// small), plus bad taxa and bad node counts. Now and then the sender
	// holds off until the block has drained.
	task automatic test_random_traffic(input int unsigned n, input bit mode);
		int unsigned       i;
		int unsigned       r;
		int unsigned       top;
		logic [TAXA_W-1:0] cur_taxa;
		logic [TAXA_W-1:0] taxa;
		logic [NODES_W-1:0] nodes;
		write_rooted(mode);
		cur_taxa = TAXA_W'($urandom_range(12, 2));
		for (i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 4) begin
				taxa = ($urandom_range(1) != 0) ? TAXA_W'($urandom_range(1, 0))
					: TAXA_W'($urandom_range(63, 33));
			end else begin
				if (r < 22)
					cur_taxa = ($urandom_range(99) < 85) ? TAXA_W'($urandom_range(12, 2))
						: TAXA_W'($urandom_range(MAX_TAXA, 13));
				taxa = cur_taxa;
			end
			top = (taxa >= 2) ? 32'(taxa) - (mode ? 1 : 2) : 0;
			r = $urandom_range(99);
			if (r < 80 && top >= 1 && top <= 31)
				nodes = NODES_W'($urandom_range(top, 1));
			else if (r < 90)
				nodes = '0;
			else
				nodes = NODES_W'($urandom);
			send_query(taxa, nodes);
			if ($urandom_range(99) < 2)
				wait_drained();
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		for (int k = 0; k < TABLE_LEN; k++)
			tree_counts[k] = '0;
		start   <= 1'b0;
		query   <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		arst_n  <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n  <= 1'b1;
		@(posedge clk);

		test_unrooted_corners();
		test_rooted_corners();
		test_random_traffic(200, 1'b0);
		test_random_traffic(200, 1'b1);
		test_random_traffic(200, 1'b0);
		test_random_traffic(200, 1'b1);

		wait_drained();
		$display("Ran %0d queries in both rooting modes, %0d result words checked.",
			queries_sent, results_seen);
		$display("Table rebuilds %0d, bad queries %0d, saturated words %0d, mismatches %0d.",
			table_rebuilds, bad_results, saturated_results, failures);
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run (every query a full rebuild
	// at 31 internal nodes plus the longest sender gap).
	initial begin
		#100_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

FILE: sim.f
src/ttct_pkg.sv
src/tree_topology_count_table.sv
dv/testbench.sv
